### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// SPT_ASSERT checks that a property holds on every rising clock edge out of reset.
// SPT_ASSERT_NEVER checks that a condition is never seen on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SPT_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SPT_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SPT_ASSERT(name, clk, rstn, prop, msg)
`define SPT_ASSERT_NEVER(name, clk, rstn, cond, msg)
`endif
`endif

### sv/spt_pkg.sv
package spt_pkg;

  // Operation codes of an input word.
  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_REMOVE  = 3'd1,
    FUNC_TEST    = 3'd2,
    FUNC_REMALL  = 3'd3,
    FUNC_PRESENT = 3'd4,
    FUNC_COUNT   = 3'd5,
    FUNC_LIST    = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned CNT_W    = 6;
  localparam logic [CNT_W-1:0] CNT_MAX  = 6'd63;
  localparam logic [CNT_W-1:0] MAX_LIST = 6'd32;

  typedef struct packed {
    logic [2:0]          func;
    logic [HANDLE_W-1:0] object_a;
    logic [HANDLE_W-1:0] object_b;
    logic [CNT_W-1:0]    max_count;
  } in_t;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [CNT_W-1:0]    partner_total;
    logic [HANDLE_W-1:0] partner;
    logic                partner_valid;
    logic                last;
  } out_t;

  // Flags from the slot comparator.
  typedef struct packed {
    logic pair_hit;
    logic obj_hit;
  } match_t;

endpackage

### sv/symmetric_pair_table.sv
// Table of unordered object pairs, each pair held once in one slot.
// An input word carries an operation (add, remove, test pair, remove all
// pairs of an object, object present, partner count, list partners) and
// the handles it concerns. A result word answers it, and a list gives one
// result word per partner, at most max_count and MAX_LIST, in slot order,
// with last set on the final one. Both channels use valid and ready. The
// block takes one word when idle, then sweeps all PAIR_SLOTS slots through
// a single comparator, one slot per cycle while no list partner waits for
// the result register, reading the handle memory at the next slot while it
// checks the present one. After the sweep an add with no duplicate and a
// free slot writes the table, and an edit or query loads its result word
// once the result register is free; then the next word can be taken. A
// list sweeps twice (count, then emit), skips the emit sweep when it has
// no partner to send, and ends the emit sweep with its final partner. The
// result register lets a new word in while the previous result waits to
// be taken; while it is held, a list sweep halts on the next partner to be
// sent. Reset empties the table at once through the per-slot used flags;
// the handle memory itself is not cleared.
module symmetric_pair_table #(
  parameter int unsigned PAIR_SLOTS  = 32,
  parameter int unsigned OBJECT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spt_pkg::out_t out_o
);

`include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(PAIR_SLOTS);
  localparam int unsigned CntW = spt_pkg::CNT_W;

  spt_pkg::state_e state_q, state_d;

  // Latched request.
  logic [2:0]             func_q, func_d;
  logic [OBJECT_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0]        maxc_q, maxc_d;

  // Sweep state.
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   pass_q, pass_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        n_q, n_d;
  logic [CntW-1:0]        k_q, k_d;
  logic                   found_q, found_d;
  logic                   dup_q, dup_d;
  logic                   free_ok_q, free_ok_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic [PAIR_SLOTS-1:0]  used_q, used_d;

  // Result register.
  logic                   out_valid_q, out_valid_d;
  spt_pkg::out_t          out_q, out_d;

  // Handle memory and comparator.
  logic                       ram_we;
  logic [2*OBJECT_BITS-1:0]   ram_rdata;
  logic [OBJECT_BITS-1:0]     slot_first, slot_second, other;
  spt_pkg::match_t            match;

  spt_ram #(
    .WIDTH (2 * OBJECT_BITS),
    .DEPTH (PAIR_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({a_q, b_q}),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  assign slot_first  = ram_rdata[2*OBJECT_BITS-1:OBJECT_BITS];
  assign slot_second = ram_rdata[OBJECT_BITS-1:0];

  spt_match #(
    .OBJECT_BITS (OBJECT_BITS)
  ) u_match (
    .first_i  (slot_first),
    .second_i (slot_second),
    .obj_a_i  (a_q),
    .obj_b_i  (b_q),
    .match_o  (match),
    .other_o  (other)
  );

  // Per-slot view of the sweep. During a sweep the memory output holds the
  // slot at idx_q, because its read address is the next index.
  logic            slot_used, pair_hit, obj_hit, at_end, out_free;
  logic            emit_hit, emit_stall, emit_last, sweep_step;
  logic            dup_next, free_ok_next, is_list, counts;
  logic [CntW-1:0] cnt_next, list_lim, n_calc;

  assign slot_used    = used_q[idx_q];
  assign pair_hit     = slot_used & match.pair_hit;
  assign obj_hit      = slot_used & match.obj_hit;
  assign at_end       = (idx_q == IdxW'(PAIR_SLOTS - 1));
  assign out_free     = ~out_valid_q | out_ready_i;
  assign is_list      = (func_q == spt_pkg::FUNC_LIST);
  assign counts       = (func_q == spt_pkg::FUNC_PRESENT) || (func_q == spt_pkg::FUNC_COUNT)
                        || is_list;
  assign emit_hit     = (state_q == spt_pkg::ST_CHECK) & pass_q & obj_hit;
  assign emit_stall   = emit_hit & ~out_free;
  assign emit_last    = ((k_q + CntW'(1)) == n_q);
  assign sweep_step   = (state_q == spt_pkg::ST_CHECK) & ~emit_stall;
  assign dup_next     = dup_q | pair_hit;
  assign free_ok_next = free_ok_q | ~slot_used;
  assign cnt_next     = (obj_hit && cnt_q != spt_pkg::CNT_MAX) ? cnt_q + CntW'(1) : cnt_q;
  assign list_lim     = (maxc_q < spt_pkg::MAX_LIST) ? maxc_q : spt_pkg::MAX_LIST;
  assign n_calc       = (cnt_next < list_lim) ? cnt_next : list_lim;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = spt_pkg::ST_CHECK;
        end
      end
      spt_pkg::ST_CHECK: begin
        if (emit_hit && !emit_stall && emit_last) begin
          state_d = spt_pkg::ST_IDLE;
        end else if (!emit_stall && at_end) begin
          if (is_list && !pass_q) begin
            state_d = (n_calc == '0) ? spt_pkg::ST_DONE : spt_pkg::ST_CHECK;
          end else if (is_list) begin
            state_d = spt_pkg::ST_IDLE;
          end else if (func_q == spt_pkg::FUNC_ADD && !dup_next && free_ok_next) begin
            state_d = spt_pkg::ST_WRITE;
          end else begin
            state_d = spt_pkg::ST_DONE;
          end
        end
      end
      spt_pkg::ST_WRITE: begin
        state_d = spt_pkg::ST_DONE;
      end
      spt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = spt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    func_d      = func_q;
    a_d         = a_q;
    b_d         = b_q;
    maxc_d      = maxc_q;
    idx_d       = idx_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    k_d         = k_q;
    found_d     = found_q;
    dup_d       = dup_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    used_d      = used_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;

    case (state_q)
      spt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        if (in_valid_i) begin
          func_d    = in_i.func;
          a_d       = OBJECT_BITS'(in_i.object_a);
          b_d       = OBJECT_BITS'(in_i.object_b);
          maxc_d    = in_i.max_count;
          pass_d    = 1'b0;
          cnt_d     = '0;
          k_d       = '0;
          found_d   = 1'b0;
          dup_d     = 1'b0;
          free_ok_d = 1'b0;
        end
      end
      spt_pkg::ST_CHECK: begin
        if (sweep_step) begin
          idx_d   = at_end ? '0 : idx_q + IdxW'(1);
          found_d = found_q | pair_hit;
          dup_d   = dup_next;
          if (!free_ok_q && !slot_used) begin
            free_ok_d  = 1'b1;
            free_idx_d = idx_q;
          end
          if (counts && !pass_q) begin
            cnt_d = cnt_next;
          end
          if (func_q == spt_pkg::FUNC_REMOVE && pair_hit) begin
            used_d[idx_q] = 1'b0;
          end
          if (func_q == spt_pkg::FUNC_REMALL && obj_hit) begin
            used_d[idx_q] = 1'b0;
          end
          if (is_list && !pass_q && at_end) begin
            pass_d = 1'b1;
            n_d    = n_calc;
            k_d    = '0;
          end
          if (emit_hit) begin
            out_valid_d         = 1'b1;
            out_d.status        = 1'b0;
            out_d.found         = 1'b0;
            out_d.partner_total = n_q;
            out_d.partner       = spt_pkg::HANDLE_W'(other);
            out_d.partner_valid = 1'b1;
            out_d.last          = emit_last;
            k_d                 = k_q + CntW'(1);
          end
        end
      end
      spt_pkg::ST_WRITE: begin
        ram_we             = 1'b1;
        used_d[free_idx_q] = 1'b1;
      end
      spt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.last          = 1'b1;
          out_d.status        = (func_q == spt_pkg::FUNC_ADD) & ~dup_q & ~free_ok_q;
          out_d.found         = ((func_q == spt_pkg::FUNC_TEST) & found_q)
                                | ((func_q == spt_pkg::FUNC_PRESENT) & (cnt_q != '0));
          out_d.partner_total = (func_q == spt_pkg::FUNC_COUNT) ? cnt_q : '0;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spt_pkg::ST_IDLE;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      k_q         <= k_d;
      n_q         <= n_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    a_q        <= a_d;
    b_q        <= b_d;
    maxc_q     <= maxc_d;
    cnt_q      <= cnt_d;
    found_q    <= found_d;
    dup_q      <= dup_d;
    free_ok_q  <= free_ok_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // At most one slot is taken per cycle.
  `SPT_ASSERT(a_used_grow, clk_i, rst_ni, $countones(used_q) <= $past($countones(used_q)) + 1, "more than one slot taken in a cycle")
  // A table write goes only to a slot that is still free.
  `SPT_ASSERT(a_write_free, clk_i, rst_ni, (state_q == spt_pkg::ST_WRITE) |-> !used_q[free_idx_q], "add overwrites a used slot")
  // The emit sweep never runs past the number of partners announced.
  `SPT_ASSERT(a_list_bound, clk_i, rst_ni, (state_q == spt_pkg::ST_CHECK && pass_q) |-> (k_q < n_q), "list emits more partners than announced")
  // A word just taken is never followed at once by another.
  `SPT_ASSERT_NEVER(a_one_word, clk_i, rst_ni, $past(in_valid_i && in_ready_o) && in_ready_o, "block ready again right after taking a word")

endmodule

### sv/spt_ram.sv
module spt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spt_match.sv
module spt_match #(
  parameter int unsigned OBJECT_BITS = 16
) (
  input  logic [OBJECT_BITS-1:0] first_i,
  input  logic [OBJECT_BITS-1:0] second_i,
  input  logic [OBJECT_BITS-1:0] obj_a_i,
  input  logic [OBJECT_BITS-1:0] obj_b_i,
  output spt_pkg::match_t        match_o,
  output logic [OBJECT_BITS-1:0] other_o
);

  logic first_a, second_a, first_b, second_b;

  assign first_a  = (first_i == obj_a_i);
  assign second_a = (second_i == obj_a_i);
  assign first_b  = (first_i == obj_b_i);
  assign second_b = (second_i == obj_b_i);

  // A pair matches in either order; the object matches at either end.
  assign match_o.pair_hit    = (first_a & second_b) | (first_b & second_a);
  assign match_o.obj_hit     = first_a | second_a;
  assign other_o             = first_a ? second_i : first_i;

endmodule
